// File: rtl/core/assert_macros.svh
// Assertion macros used by urfi_back.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define URFI_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Checks that a condition implies another at the same clock edge.
`define URFI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/urfi_pkg.sv
`timescale 1ns / 1ps
package urfi_pkg;

  localparam int TX_DEPTH_DEF = 128;
  localparam int RX_DEPTH_DEF = 128;

  typedef enum logic [2:0] {
    CL_READ, CL_WRITE, CL_RXBYTE, CL_BREAK, CL_SLOT, CL_NOP
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } item_t;

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_RXB   = 3'd2;
  localparam logic [2:0] CMD_BRK   = 3'd3;
  localparam logic [2:0] CMD_SLOT  = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DIR = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic [3:0] R_IRQ_STATE   = 4'd0;
  localparam logic [3:0] R_IRQ_EN      = 4'd1;
  localparam logic [3:0] R_IRQ_FORCE   = 4'd2;
  localparam logic [3:0] R_ALERT_FORCE = 4'd3;
  localparam logic [3:0] R_CTRL        = 4'd4;
  localparam logic [3:0] R_STAT        = 4'd5;
  localparam logic [3:0] R_RDATA       = 4'd6;
  localparam logic [3:0] R_WDATA       = 4'd7;
  localparam logic [3:0] R_QCTRL       = 4'd8;
  localparam logic [3:0] R_QSTAT       = 4'd9;
  localparam logic [3:0] R_OVRD        = 4'd10;
  localparam logic [3:0] R_VAL         = 4'd11;
  localparam logic [3:0] R_TIMEOUT     = 4'd12;

  localparam int IRQ_TXWM    = 0;
  localparam int IRQ_RXWM    = 1;
  localparam int IRQ_TXDONE  = 2;
  localparam int IRQ_RXOVF   = 3;
  localparam int IRQ_BREAK   = 5;
  localparam int IRQ_TXEMPTY = 8;

  localparam int CTL_TX    = 0;
  localparam int CTL_RX    = 1;
  localparam int CTL_SLPBK = 4;

  localparam logic [0:0] CFG_BREAK_LOW    = 1'd0;
  localparam logic [0:0] CFG_BREAK_TOGGLE = 1'd1;

  function automatic logic [7:0] rx_wm_level(input logic [2:0] l);
    return (l == 3'd7) ? 8'd126 : (8'd1 << l);
  endfunction

  function automatic logic [7:0] tx_wm_level(input logic [2:0] l);
    return (l == 3'd7) ? 8'd64 : (8'd1 << l);
  endfunction

endpackage

// File: rtl/core/urfi_front.sv
`timescale 1ns / 1ps
module urfi_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        cmd,
  input  logic [3:0]        reg_index,
  input  logic [31:0]       write_data,
  input  logic [7:0]        rx_byte,
  output logic              q_valid,
  output urfi_pkg::item_t   q_item,
  input  logic              deq
);
  import urfi_pkg::*;

  item_t      q_mem [2];
  logic       wp, rp;
  logic [1:0] q_cnt;
  cls_t       cls;
  logic       enq;

  always_comb begin
    case (cmd)
      CMD_READ:  cls = CL_READ;
      CMD_WRITE: cls = CL_WRITE;
      CMD_RXB:   cls = CL_RXBYTE;
      CMD_BRK:   cls = CL_BREAK;
      CMD_SLOT:  cls = CL_SLOT;
      default:   cls = CL_NOP;
    endcase
  end

  assign in_stall = (q_cnt == 2'd2);
  assign enq      = in_valid && !in_stall;
  assign q_valid  = (q_cnt != 2'd0);
  assign q_item   = q_mem[rp];

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wp] <= '{cls: cls, reg_index: reg_index, write_data: write_data,
                     rx_byte: rx_byte};
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      if (enq) wp <= !wp;
      if (deq) rp <= !rp;
      q_cnt <= q_cnt + 2'(enq) - 2'(deq);
    end
  end

endmodule

// File: rtl/core/urfi_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module urfi_back #(
  parameter int TX_DEPTH = urfi_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = urfi_pkg::RX_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              q_valid,
  input  urfi_pkg::item_t   q_item,
  output logic              deq,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       read_data,
  output logic [1:0]        access_status,
  output logic              tx_valid,
  output logic [7:0]        tx_byte,
  output logic [8:0]        irq_lines
);
  import urfi_pkg::*;

  localparam int TCW = $clog2(TX_DEPTH + 1);
  localparam int TPW = $clog2(TX_DEPTH);
  localparam int RCW = $clog2(RX_DEPTH + 1);
  localparam int RPW = $clog2(RX_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_RDWAIT, S_TXWAIT, S_LOOP} state_t;

  state_t state, state_next;

  logic        brk_low, brk_tog;
  logic [8:0]  pending, pending_next;
  logic [8:0]  enable, enable_next;
  logic [31:0] ctrl, ctrl_next;
  logic [5:0]  levels, levels_next;
  logic        alert, alert_next;
  logic [1:0]  ovrd, ovrd_next;
  logic [31:0] tmo, tmo_next;
  logic [TCW-1:0] tx_count, tx_count_next;
  logic [TPW-1:0] tx_head, tx_head_next;
  logic [RCW-1:0] rx_count, rx_count_next;
  logic [RPW-1:0] rx_head, rx_head_next;
  logic [6:0]  mark, mark_next;
  logic        brk_held, brk_held_next;
  logic        pend, pend_next;
  logic        dropped, dropped_next;

  logic [7:0]  tx_mem [TX_DEPTH];
  logic [7:0]  rx_mem [RX_DEPTH];
  logic [7:0]  tx_rdata, rx_rdata;
  logic        tx_we, tx_re, rx_we, rx_re;
  logic [7:0]  tx_wd, rx_wd;
  logic [TPW-1:0] tx_wa;
  logic [RPW-1:0] rx_wa;
  logic [TCW:0] tx_tail_sum;
  logic [RCW:0] rx_tail_sum;

  logic        res_load, res_tv;
  logic [31:0] res_rd;
  logic [1:0]  res_st;
  logic [7:0]  res_tb;
  logic        out_free;
  logic [7:0]  lvl;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    tx_tail_sum = (TCW+1)'(tx_head) + (TCW+1)'(tx_count);
    if (tx_tail_sum >= (TCW+1)'(TX_DEPTH)) tx_tail_sum = tx_tail_sum - (TCW+1)'(TX_DEPTH);
    rx_tail_sum = (RCW+1)'(rx_head) + (RCW+1)'(rx_count);
    if (rx_tail_sum >= (RCW+1)'(RX_DEPTH)) rx_tail_sum = rx_tail_sum - (RCW+1)'(RX_DEPTH);
  end

  assign tx_wa = tx_tail_sum[TPW-1:0];
  assign rx_wa = rx_tail_sum[RPW-1:0];

  always_comb begin
    state_next    = state;
    pending_next  = pending;
    enable_next   = enable;
    ctrl_next     = ctrl;
    levels_next   = levels;
    alert_next    = alert;
    ovrd_next     = ovrd;
    tmo_next      = tmo;
    tx_count_next = tx_count;
    tx_head_next  = tx_head;
    rx_count_next = rx_count;
    rx_head_next  = rx_head;
    mark_next     = mark;
    brk_held_next = brk_held;
    pend_next     = pend;
    dropped_next  = dropped;
    tx_we = 1'b0;
    tx_re = 1'b0;
    rx_we = 1'b0;
    rx_re = 1'b0;
    tx_wd = q_item.write_data[7:0];
    rx_wd = q_item.rx_byte;
    deq      = 1'b0;
    res_load = 1'b0;
    res_rd   = 32'd0;
    res_st   = ST_OK;
    res_tv   = 1'b0;
    res_tb   = 8'd0;
    lvl      = 8'd0;
    case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          deq      = 1'b1;
          res_load = 1'b1;
          case (q_item.cls)
            CL_READ: begin
              case (q_item.reg_index)
                R_IRQ_STATE:   res_rd = 32'(pending);
                R_IRQ_EN:      res_rd = 32'(enable);
                R_CTRL:        res_rd = ctrl;
                R_QCTRL:       res_rd = {24'd0, levels, 2'd0};
                R_STAT: begin
                  res_rd = 32'h10;
                  if (rx_count == '0) res_rd[5] = 1'b1;
                  else if (rx_count == RCW'(RX_DEPTH)) res_rd[1] = 1'b1;
                  if (tx_count == '0) res_rd[3:2] = 2'b11;
                  else if (tx_count == TCW'(TX_DEPTH)) res_rd[0] = 1'b1;
                  if (!ctrl[CTL_TX]) res_rd[3] = 1'b1;
                end
                R_RDATA: begin
                  if (ctrl[CTL_RX] && rx_count != '0) begin
                    rx_re         = 1'b1;
                    rx_head_next  = (rx_head == RPW'(RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
                    rx_count_next = rx_count - 1'b1;
                    res_load      = 1'b0;
                    state_next    = S_RDWAIT;
                  end
                end
                R_QSTAT:       res_rd = {8'd0, 8'(rx_count), 8'd0, 8'(tx_count)};
                R_OVRD:        res_rd = 32'(ovrd);
                R_VAL:         res_rd = (brk_held && brk_low) ? 32'd0 : 32'hFFFF;
                R_TIMEOUT:     res_rd = tmo;
                R_IRQ_FORCE, R_ALERT_FORCE, R_WDATA: res_st = ST_DIR;
                default:       res_st = ST_BAD;
              endcase
            end
            CL_WRITE: begin
              case (q_item.reg_index)
                R_IRQ_STATE:   pending_next = pending & ~q_item.write_data[8:0];
                R_IRQ_EN:      enable_next  = q_item.write_data[8:0];
                R_IRQ_FORCE:   pending_next = pending | q_item.write_data[8:0];
                R_ALERT_FORCE: alert_next   = q_item.write_data[0];
                R_CTRL:        ctrl_next    = q_item.write_data;
                R_WDATA: begin
                  if (tx_count < TCW'(TX_DEPTH)) begin
                    tx_we         = 1'b1;
                    tx_count_next = tx_count + 1'b1;
                    lvl           = tx_wm_level(levels[5:3]);
                    mark_next     = (9'(tx_count_next) < 9'(lvl)) ? 7'd0 : lvl[6:0];
                    if (ctrl[CTL_TX] && ctrl[CTL_SLPBK]) begin
                      res_load     = 1'b0;
                      pend_next    = 1'b0;
                      dropped_next = 1'b0;
                      state_next   = S_LOOP;
                    end
                  end
                end
                R_QCTRL: begin
                  levels_next = q_item.write_data[7:2];
                  if (q_item.write_data[0]) begin
                    rx_count_next = '0;
                    rx_head_next  = '0;
                    pending_next[IRQ_RXWM]  = 1'b0;
                    pending_next[IRQ_RXOVF] = 1'b0;
                  end
                  if (q_item.write_data[1]) begin
                    tx_count_next = '0;
                    tx_head_next  = '0;
                    pending_next[IRQ_TXEMPTY] = 1'b1;
                    pending_next[IRQ_TXDONE]  = 1'b1;
                    if (mark != 7'd0) begin
                      pending_next[IRQ_TXWM] = 1'b1;
                      mark_next = 7'd0;
                    end
                  end
                end
                R_OVRD:    ovrd_next = {q_item.write_data[1], 1'b0};
                R_TIMEOUT: tmo_next  = q_item.write_data & 32'h80FFFFFF;
                R_STAT, R_RDATA, R_QSTAT, R_VAL: res_st = ST_DIR;
                default: res_st = ST_BAD;
              endcase
            end
            CL_RXBYTE: begin
              if (ctrl[CTL_RX]) begin
                if (rx_count < RCW'(RX_DEPTH)) begin
                  rx_we         = 1'b1;
                  rx_count_next = rx_count + 1'b1;
                end else begin
                  pending_next[IRQ_RXOVF] = 1'b1;
                end
                if (!brk_tog) brk_held_next = 1'b0;
                if (9'(rx_count_next) >= 9'(rx_wm_level(levels[2:0])))
                  pending_next[IRQ_RXWM] = 1'b1;
              end
            end
            CL_BREAK: begin
              if (!brk_held || !brk_low) begin
                pending_next[IRQ_BREAK] = 1'b1;
                brk_held_next = 1'b1;
              end else if (brk_tog) begin
                brk_held_next = 1'b0;
              end
            end
            CL_SLOT: begin
              if (ctrl[CTL_TX] && tx_count != '0) begin
                res_load   = 1'b0;
                pend_next    = 1'b0;
                dropped_next = 1'b0;
                if (ctrl[CTL_SLPBK]) begin
                  state_next = S_LOOP;
                end else begin
                  tx_re         = 1'b1;
                  tx_head_next  = (tx_head == TPW'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
                  tx_count_next = tx_count - 1'b1;
                  state_next    = S_TXWAIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RDWAIT: begin
        res_load   = 1'b1;
        res_rd     = 32'(rx_rdata);
        state_next = S_IDLE;
      end
      S_TXWAIT: begin
        res_load   = 1'b1;
        res_tv     = 1'b1;
        res_tb     = tx_rdata;
        state_next = S_IDLE;
        if (tx_count == '0) begin
          pending_next[IRQ_TXEMPTY] = 1'b1;
          pending_next[IRQ_TXDONE]  = 1'b1;
        end
        if (mark != 7'd0 && 8'(tx_count) < 8'(mark)) begin
          pending_next[IRQ_TXWM] = 1'b1;
          mark_next = 7'd0;
        end
      end
      S_LOOP: begin
        rx_wd = tx_rdata;
        if (pend) begin
          if (rx_count < RCW'(RX_DEPTH)) begin
            rx_we         = 1'b1;
            rx_count_next = rx_count + 1'b1;
          end else begin
            dropped_next = 1'b1;
          end
        end
        pend_next = 1'b0;
        if (tx_count != '0) begin
          tx_re         = 1'b1;
          tx_head_next  = (tx_head == TPW'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
          tx_count_next = tx_count - 1'b1;
          pend_next     = 1'b1;
        end else if (!pend) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (!brk_tog) brk_held_next = 1'b0;
          if (dropped) pending_next[IRQ_RXOVF] = 1'b1;
          if (9'(rx_count) >= 9'(rx_wm_level(levels[2:0])))
            pending_next[IRQ_RXWM] = 1'b1;
          pending_next[IRQ_TXEMPTY] = 1'b1;
          pending_next[IRQ_TXDONE]  = 1'b1;
          if (mark != 7'd0) begin
            pending_next[IRQ_TXWM] = 1'b1;
            mark_next = 7'd0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_wa] <= tx_wd;
    if (tx_re) tx_rdata <= tx_mem[tx_head];
  end

  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_wa] <= rx_wd;
    if (rx_re) rx_rdata <= rx_mem[rx_head];
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      read_data     <= res_rd;
      access_status <= res_st;
      tx_valid      <= res_tv;
      tx_byte       <= res_tb;
      irq_lines     <= pending_next & enable_next;
    end
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      brk_low   <= 1'b0;
      brk_tog   <= 1'b0;
      pending   <= '0;
      enable    <= '0;
      ctrl      <= '0;
      levels    <= '0;
      alert     <= 1'b0;
      ovrd      <= '0;
      tmo       <= '0;
      tx_count  <= '0;
      tx_head   <= '0;
      rx_count  <= '0;
      rx_head   <= '0;
      mark      <= '0;
      brk_held  <= 1'b0;
      pend      <= 1'b0;
      dropped   <= 1'b0;
    end else begin
      state     <= state_next;
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_index == CFG_BREAK_LOW) brk_low <= cfg_data[0];
      if (cfg_valid && cfg_index == CFG_BREAK_TOGGLE) brk_tog <= cfg_data[0];
      pending   <= pending_next;
      enable    <= enable_next;
      ctrl      <= ctrl_next;
      levels    <= levels_next;
      alert     <= alert_next;
      ovrd      <= ovrd_next;
      tmo       <= tmo_next;
      tx_count  <= tx_count_next;
      tx_head   <= tx_head_next;
      rx_count  <= rx_count_next;
      rx_head   <= rx_head_next;
      mark      <= mark_next;
      brk_held  <= brk_held_next;
      pend      <= pend_next;
      dropped   <= dropped_next;
    end
  end

  `URFI_ASSERT(a_tx_bound, tx_count <= TCW'(TX_DEPTH))
  `URFI_ASSERT(a_rx_bound, rx_count <= RCW'(RX_DEPTH))
  `URFI_ASSERT_IMP(a_busy_no_deq, state != S_IDLE, !deq)
  `URFI_ASSERT_IMP(a_load_free, res_load, out_free)

endmodule

// File: rtl/core/uart_register_fifo_interrupt_block_unit.sv
`timescale 1ns / 1ps
// UART register block with transmit and receive byte FIFOs. Items enter a
// two-entry queue and are carried out one at a time by the back end. A
// receive pop or a transmit slot passes through a wait state because the FIFO
// memories have a registered read port, and a loopback flush moves the bytes
// of the transmit FIFO into the receive FIFO, one byte per cycle through the
// memory ports.
module uart_register_fifo_interrupt_block_unit #(
  parameter int TX_DEPTH = urfi_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = urfi_pkg::RX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic [1:0]  access_status,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic [8:0]  irq_lines
);
  import urfi_pkg::*;

  logic  q_valid, deq;
  item_t q_item;

  urfi_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .reg_index(reg_index), .write_data(write_data),
    .rx_byte(rx_byte), .q_valid(q_valid), .q_item(q_item), .deq(deq)
  );

  urfi_back #(.TX_DEPTH(TX_DEPTH), .RX_DEPTH(RX_DEPTH)) u_back (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .q_valid(q_valid),
    .q_item(q_item), .deq(deq), .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .access_status(access_status),
    .tx_valid(tx_valid), .tx_byte(tx_byte), .irq_lines(irq_lines)
  );

endmodule
